@@ hdl/psd_pkg.sv @@
package psd_pkg;

   // field and intermediate widths
   localparam int COORD_W   = 16;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int NUM_W     = PROD_W + 1;
   localparam int DEN_W     = PROD_W;
   localparam int SQ_W      = PROD_W;
   localparam int HALF_W    = DIFF_W;
   localparam int DIST_W    = 17;

   // foot divider: (2*|d|*num + den) / (2*den)
   localparam int FDIV_N_W  = 52;
   localparam int FDIV_D_W  = DEN_W + 1;
   localparam int FDIV_Q_W  = 17;

   // cross product divider: cr^2 / den
   localparam int CDIV_N_W  = 2 * DEN_W;
   localparam int CDIV_D_W  = DEN_W;
   localparam int CDIV_Q_W  = 34;

   localparam int ROOT_IN_W = CDIV_Q_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] end_a_x;
      logic signed [COORD_W-1:0] end_a_y;
      logic signed [COORD_W-1:0] end_b_x;
      logic signed [COORD_W-1:0] end_b_y;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0]         distance;
      logic                      foot_inside;
      logic signed [COORD_W-1:0] foot_x;
      logic signed [COORD_W-1:0] foot_y;
   } rsp_type;

   // control carried beside the square root
   typedef struct packed {
      logic              foot_in;
      logic              use_div;
      logic              use_axis;
      logic [DIST_W-1:0] axis_dist;
   } final_side_type;

   // per coordinate data carried beside a foot divider
   typedef struct packed {
      logic signed [COORD_W-1:0] base;
      logic                      neg;
   } foot_side_type;

   // everything carried beside the cross product divider
   typedef struct packed {
      logic [FDIV_N_W-1:0]  foot_n_x;
      logic [FDIV_N_W-1:0]  foot_n_y;
      logic [FDIV_D_W-1:0]  foot_d;
      logic [SQ_W-1:0]      min_sq;
      final_side_type       fin;
      foot_side_type        fx;
      foot_side_type        fy;
   } cr_side_type;

endpackage

@@ hdl/psd_chan_if.sv @@
interface psd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/point_segment_distance.sv @@
// throughput: one item per cycle while the result is not stalled; 5 geometry
//   stages, a 34-stage divider for cross^2/den, then the 17-stage square root
//   beside two 17-stage foot dividers
// a stalled result holds the whole pipeline; no bubble squeezing
// reset (synchronous) clears every valid bit; the block is ready the next cycle
module point_segment_distance (
   input logic        clock,
   input logic        reset,
   psd_chan_if.sink   req_port,
   psd_chan_if.source rsp_port
);

   localparam int CS_W = $bits(psd_pkg::cr_side_type);
   localparam int FS_W = $bits(psd_pkg::final_side_type);
   localparam int XS_W = $bits(psd_pkg::foot_side_type);

   logic                          adv;
   logic                          fr_valid;
   logic [psd_pkg::CDIV_N_W-1:0]  fr_cr_sq;
   logic [psd_pkg::DEN_W-1:0]     fr_den;
   psd_pkg::cr_side_type          fr_side;

   logic                          cd_valid;
   logic [psd_pkg::CDIV_Q_W-1:0]  cd_quo;
   logic [CS_W-1:0]               cd_side_vec;
   psd_pkg::cr_side_type          cd_side;
   logic [psd_pkg::ROOT_IN_W-1:0] root_in;

   logic                          sq_valid, fx_valid, fy_valid;
   logic [psd_pkg::DIST_W-1:0]    sq_root;
   logic [FS_W-1:0]               sq_side_vec;
   psd_pkg::final_side_type       sq_side;
   logic [psd_pkg::FDIV_Q_W-1:0]  fx_quo, fy_quo;
   logic [XS_W-1:0]               fx_side_vec, fy_side_vec;
   psd_pkg::foot_side_type        fx_side, fy_side;

   logic signed [psd_pkg::DIFF_W-1:0] off_x, off_y, sum_x, sum_y;
   psd_pkg::rsp_type              rsp_in, rsp_ff;
   logic                          rsp_valid_ff;

   // whole pipeline moves when the output slot is free or being taken
   assign adv            = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = adv;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (req_port.valid),
      .in_data   (req_port.data),
      .out_valid (fr_valid),
      .cr_sq     (fr_cr_sq),
      .den       (fr_den),
      .side      (fr_side)
   );

   // squared perpendicular distance times den, divided by den
   psd_divider #(
      .N_W    (psd_pkg::CDIV_N_W),
      .D_W    (psd_pkg::CDIV_D_W),
      .Q_W    (psd_pkg::CDIV_Q_W),
      .SIDE_W (CS_W)
   ) u_cr_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (fr_valid),
      .dividend  (fr_cr_sq),
      .divisor   (fr_den),
      .in_side   (fr_side),
      .out_valid (cd_valid),
      .quotient  (cd_quo),
      .out_side  (cd_side_vec)
   );

   assign cd_side = psd_pkg::cr_side_type'(cd_side_vec);
   assign root_in = cd_side.fin.use_div ? cd_quo : cd_side.min_sq;

   psd_isqrt #(
      .IN_W   (psd_pkg::ROOT_IN_W),
      .SIDE_W (FS_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (cd_valid),
      .value     (root_in),
      .in_side   (cd_side.fin),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side_vec)
   );

   // rounded foot offsets, in step with the square root
   psd_divider #(
      .N_W    (psd_pkg::FDIV_N_W),
      .D_W    (psd_pkg::FDIV_D_W),
      .Q_W    (psd_pkg::FDIV_Q_W),
      .SIDE_W (XS_W)
   ) u_fx_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (cd_valid),
      .dividend  (cd_side.foot_n_x),
      .divisor   (cd_side.foot_d),
      .in_side   (cd_side.fx),
      .out_valid (fx_valid),
      .quotient  (fx_quo),
      .out_side  (fx_side_vec)
   );

   psd_divider #(
      .N_W    (psd_pkg::FDIV_N_W),
      .D_W    (psd_pkg::FDIV_D_W),
      .Q_W    (psd_pkg::FDIV_Q_W),
      .SIDE_W (XS_W)
   ) u_fy_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (cd_valid),
      .dividend  (cd_side.foot_n_y),
      .divisor   (cd_side.foot_d),
      .in_side   (cd_side.fy),
      .out_valid (fy_valid),
      .quotient  (fy_quo),
      .out_side  (fy_side_vec)
   );

   assign sq_side = psd_pkg::final_side_type'(sq_side_vec);
   assign fx_side = psd_pkg::foot_side_type'(fx_side_vec);
   assign fy_side = psd_pkg::foot_side_type'(fy_side_vec);

   // result assembly
   always_comb begin
      off_x = fx_side.neg ? -$signed(fx_quo) : $signed(fx_quo);
      off_y = fy_side.neg ? -$signed(fy_quo) : $signed(fy_quo);
      sum_x = psd_pkg::DIFF_W'(fx_side.base) + off_x;
      sum_y = psd_pkg::DIFF_W'(fy_side.base) + off_y;

      rsp_in.distance    = sq_side.use_axis ? sq_side.axis_dist : sq_root;
      rsp_in.foot_inside = sq_side.foot_in;
      if (!sq_side.foot_in) begin
         rsp_in.foot_x = '0;
         rsp_in.foot_y = '0;
      end else if (sq_side.use_div) begin
         rsp_in.foot_x = sum_x[psd_pkg::COORD_W-1:0];
         rsp_in.foot_y = sum_y[psd_pkg::COORD_W-1:0];
      end else begin
         rsp_in.foot_x = fx_side.base;
         rsp_in.foot_y = fy_side.base;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sq_valid;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_ff;

   // parallel lanes stay in step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (sq_valid == fx_valid) && (sq_valid == fy_valid))
      else $error("square root and foot divider lanes out of step");

   // a foot that is not inside reads as zero
   a_foot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.data.foot_inside |->
         rsp_port.data.foot_x == '0 && rsp_port.data.foot_y == '0)
      else $error("foot not cleared when outside");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_port.valid)
      else $error("result offered after reset");

endmodule

@@ hdl/psd_front.sv @@
module psd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  psd_pkg::req_type           in_data,
   output logic                       out_valid,
   output logic [psd_pkg::CDIV_N_W-1:0] cr_sq,
   output logic [psd_pkg::DEN_W-1:0]  den,
   output psd_pkg::cr_side_type       side
);

   typedef struct packed {
      logic signed [psd_pkg::DIFF_W-1:0]  dx, dy, rax, ray, rbx, rby;
      logic signed [psd_pkg::COORD_W-1:0] ax, ay, px, py;
      logic vert, horiz, v_in, h_in;
   } s1_type;

   typedef struct packed {
      logic signed [psd_pkg::PROD_W-1:0]  p_xrx, p_yry, p_xx, p_yy, p_xry, p_yrx;
      logic signed [psd_pkg::PROD_W-1:0]  p_ax, p_ay, p_bx, p_by;
      logic signed [psd_pkg::DIFF_W-1:0]  dx, dy, rax, ray;
      logic signed [psd_pkg::COORD_W-1:0] ax, ay, px, py;
      logic vert, horiz, v_in, h_in;
   } s2_type;

   typedef struct packed {
      logic signed [psd_pkg::NUM_W-1:0]   num, cr;
      logic [psd_pkg::DEN_W-1:0]          den;
      logic [psd_pkg::SQ_W-1:0]           da, db;
      logic signed [psd_pkg::DIFF_W-1:0]  dx, dy, rax, ray;
      logic signed [psd_pkg::COORD_W-1:0] ax, ay, px, py;
      logic vert, horiz, v_in, h_in;
   } s3_type;

   typedef struct packed {
      logic [psd_pkg::PROD_W-1:0] pxl, pxh, pyl, pyh, chh, chl, cll;
      logic [psd_pkg::DEN_W-1:0]  den;
      logic [psd_pkg::SQ_W-1:0]   min_sq;
      psd_pkg::final_side_type    fin;
      psd_pkg::foot_side_type     fx, fy;
   } s4_type;

   typedef struct packed {
      logic [psd_pkg::CDIV_N_W-1:0] cr_sq;
      logic [psd_pkg::DEN_W-1:0]    den;
      psd_pkg::cr_side_type         side;
   } s5_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   logic [4:0] valid_ff;

   logic [psd_pkg::DIFF_W-1:0]  mag_dx, mag_dy, mag_rax, mag_ray;
   logic [psd_pkg::NUM_W-1:0]   cr_abs;
   logic [psd_pkg::DEN_W-1:0]   cr_mag, num_u;
   logic                        gen_in;
   logic [psd_pkg::CDIV_N_W-4:0] m_x, m_y;

   // stage 1: differences and axis tests
   always_comb begin
      s1_in.dx    = {in_data.end_b_x[15], in_data.end_b_x} - {in_data.end_a_x[15], in_data.end_a_x};
      s1_in.dy    = {in_data.end_b_y[15], in_data.end_b_y} - {in_data.end_a_y[15], in_data.end_a_y};
      s1_in.rax   = {in_data.point_x[15], in_data.point_x} - {in_data.end_a_x[15], in_data.end_a_x};
      s1_in.ray   = {in_data.point_y[15], in_data.point_y} - {in_data.end_a_y[15], in_data.end_a_y};
      s1_in.rbx   = {in_data.point_x[15], in_data.point_x} - {in_data.end_b_x[15], in_data.end_b_x};
      s1_in.rby   = {in_data.point_y[15], in_data.point_y} - {in_data.end_b_y[15], in_data.end_b_y};
      s1_in.ax    = in_data.end_a_x;
      s1_in.ay    = in_data.end_a_y;
      s1_in.px    = in_data.point_x;
      s1_in.py    = in_data.point_y;
      s1_in.vert  = in_data.end_a_x == in_data.end_b_x;
      s1_in.horiz = in_data.end_a_y == in_data.end_b_y;
      s1_in.v_in  = (in_data.point_y > in_data.end_a_y && in_data.point_y < in_data.end_b_y) ||
                    (in_data.point_y < in_data.end_a_y && in_data.point_y > in_data.end_b_y);
      s1_in.h_in  = (in_data.point_x > in_data.end_a_x && in_data.point_x < in_data.end_b_x) ||
                    (in_data.point_x < in_data.end_a_x && in_data.point_x > in_data.end_b_x);
   end

   // stage 2: all products of differences
   always_comb begin
      s2_in.p_xrx = s1_ff.dx * s1_ff.rax;
      s2_in.p_yry = s1_ff.dy * s1_ff.ray;
      s2_in.p_xx  = s1_ff.dx * s1_ff.dx;
      s2_in.p_yy  = s1_ff.dy * s1_ff.dy;
      s2_in.p_xry = s1_ff.dx * s1_ff.ray;
      s2_in.p_yrx = s1_ff.dy * s1_ff.rax;
      s2_in.p_ax  = s1_ff.rax * s1_ff.rax;
      s2_in.p_ay  = s1_ff.ray * s1_ff.ray;
      s2_in.p_bx  = s1_ff.rbx * s1_ff.rbx;
      s2_in.p_by  = s1_ff.rby * s1_ff.rby;
      s2_in.dx    = s1_ff.dx;
      s2_in.dy    = s1_ff.dy;
      s2_in.rax   = s1_ff.rax;
      s2_in.ray   = s1_ff.ray;
      s2_in.ax    = s1_ff.ax;
      s2_in.ay    = s1_ff.ay;
      s2_in.px    = s1_ff.px;
      s2_in.py    = s1_ff.py;
      s2_in.vert  = s1_ff.vert;
      s2_in.horiz = s1_ff.horiz;
      s2_in.v_in  = s1_ff.v_in;
      s2_in.h_in  = s1_ff.h_in;
   end

   // stage 3: dot product, cross product, squared lengths
   always_comb begin
      s3_in.num   = psd_pkg::NUM_W'(s2_ff.p_xrx) + psd_pkg::NUM_W'(s2_ff.p_yry);
      s3_in.cr    = psd_pkg::NUM_W'(s2_ff.p_xry) - psd_pkg::NUM_W'(s2_ff.p_yrx);
      s3_in.den   = s2_ff.p_xx[psd_pkg::DEN_W-1:0] + s2_ff.p_yy[psd_pkg::DEN_W-1:0];
      s3_in.da    = s2_ff.p_ax[psd_pkg::SQ_W-1:0] + s2_ff.p_ay[psd_pkg::SQ_W-1:0];
      s3_in.db    = s2_ff.p_bx[psd_pkg::SQ_W-1:0] + s2_ff.p_by[psd_pkg::SQ_W-1:0];
      s3_in.dx    = s2_ff.dx;
      s3_in.dy    = s2_ff.dy;
      s3_in.rax   = s2_ff.rax;
      s3_in.ray   = s2_ff.ray;
      s3_in.ax    = s2_ff.ax;
      s3_in.ay    = s2_ff.ay;
      s3_in.px    = s2_ff.px;
      s3_in.py    = s2_ff.py;
      s3_in.vert  = s2_ff.vert;
      s3_in.horiz = s2_ff.horiz;
      s3_in.v_in  = s2_ff.v_in;
      s3_in.h_in  = s2_ff.h_in;
   end

   // stage 4: classify, magnitudes and partial products
   always_comb begin
      mag_dx  = s3_ff.dx[psd_pkg::DIFF_W-1] ? psd_pkg::DIFF_W'(-s3_ff.dx) : psd_pkg::DIFF_W'(s3_ff.dx);
      mag_dy  = s3_ff.dy[psd_pkg::DIFF_W-1] ? psd_pkg::DIFF_W'(-s3_ff.dy) : psd_pkg::DIFF_W'(s3_ff.dy);
      mag_rax = s3_ff.rax[psd_pkg::DIFF_W-1] ? psd_pkg::DIFF_W'(-s3_ff.rax)
                                             : psd_pkg::DIFF_W'(s3_ff.rax);
      mag_ray = s3_ff.ray[psd_pkg::DIFF_W-1] ? psd_pkg::DIFF_W'(-s3_ff.ray)
                                             : psd_pkg::DIFF_W'(s3_ff.ray);
      cr_abs  = s3_ff.cr[psd_pkg::NUM_W-1] ? psd_pkg::NUM_W'(-s3_ff.cr) : psd_pkg::NUM_W'(s3_ff.cr);
      cr_mag  = cr_abs[psd_pkg::DEN_W-1:0];
      num_u   = s3_ff.num[psd_pkg::DEN_W-1:0];
      gen_in  = !s3_ff.vert && !s3_ff.horiz && (s3_ff.num > 0) && (num_u < s3_ff.den);

      s4_in.pxl = mag_dx * num_u[psd_pkg::HALF_W-1:0];
      s4_in.pxh = mag_dx * num_u[psd_pkg::DEN_W-1:psd_pkg::HALF_W];
      s4_in.pyl = mag_dy * num_u[psd_pkg::HALF_W-1:0];
      s4_in.pyh = mag_dy * num_u[psd_pkg::DEN_W-1:psd_pkg::HALF_W];
      s4_in.chh = cr_mag[psd_pkg::DEN_W-1:psd_pkg::HALF_W] * cr_mag[psd_pkg::DEN_W-1:psd_pkg::HALF_W];
      s4_in.chl = cr_mag[psd_pkg::DEN_W-1:psd_pkg::HALF_W] * cr_mag[psd_pkg::HALF_W-1:0];
      s4_in.cll = cr_mag[psd_pkg::HALF_W-1:0] * cr_mag[psd_pkg::HALF_W-1:0];
      s4_in.den = s3_ff.den;
      s4_in.min_sq = (s3_ff.da < s3_ff.db) ? s3_ff.da : s3_ff.db;

      s4_in.fin.use_div   = gen_in;
      s4_in.fin.use_axis  = s3_ff.vert ? s3_ff.v_in : (s3_ff.horiz && s3_ff.h_in);
      s4_in.fin.foot_in   = s3_ff.vert ? s3_ff.v_in : (s3_ff.horiz ? s3_ff.h_in : gen_in);
      s4_in.fin.axis_dist = s3_ff.vert ? mag_rax : mag_ray;

      // vertical keeps a.x and p.y, horizontal keeps p.x and a.y
      s4_in.fx.base = (!s3_ff.vert && s3_ff.horiz) ? s3_ff.px : s3_ff.ax;
      s4_in.fy.base = s3_ff.vert ? s3_ff.py : s3_ff.ay;
      s4_in.fx.neg  = s3_ff.dx[psd_pkg::DIFF_W-1];
      s4_in.fy.neg  = s3_ff.dy[psd_pkg::DIFF_W-1];
   end

   // stage 5: assemble wide dividends
   always_comb begin
      m_x = (psd_pkg::CDIV_N_W-3)'(s4_ff.pxl) + {s4_ff.pxh, {psd_pkg::HALF_W{1'b0}}};
      m_y = (psd_pkg::CDIV_N_W-3)'(s4_ff.pyl) + {s4_ff.pyh, {psd_pkg::HALF_W{1'b0}}};
      s5_in.side.foot_n_x = psd_pkg::FDIV_N_W'({m_x, 1'b0}) + psd_pkg::FDIV_N_W'(s4_ff.den);
      s5_in.side.foot_n_y = psd_pkg::FDIV_N_W'({m_y, 1'b0}) + psd_pkg::FDIV_N_W'(s4_ff.den);
      s5_in.side.foot_d   = {s4_ff.den, 1'b0};
      s5_in.side.min_sq   = s4_ff.min_sq;
      s5_in.side.fin      = s4_ff.fin;
      s5_in.side.fx       = s4_ff.fx;
      s5_in.side.fy       = s4_ff.fy;
      s5_in.cr_sq = {s4_ff.chh, {psd_pkg::DEN_W{1'b0}}} +
                    psd_pkg::CDIV_N_W'({s4_ff.chl, {(psd_pkg::HALF_W + 1){1'b0}}}) +
                    psd_pkg::CDIV_N_W'(s4_ff.cll);
      s5_in.den = s4_ff.den;
   end

   // stage registers, all advancing together
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
      if (enable) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign cr_sq     = s5_ff.cr_sq;
   assign den       = s5_ff.den;
   assign side      = s5_ff.side;

endmodule

@@ hdl/psd_divider.sv @@
module psd_divider #(
   parameter int N_W    = psd_pkg::FDIV_N_W,
   parameter int D_W    = psd_pkg::FDIV_D_W,
   parameter int Q_W    = psd_pkg::FDIV_Q_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [N_W-1:0]    dividend,
   input  logic [D_W-1:0]    divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    quotient,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

   logic              valid_ff [Q_W];
   logic [N_W-1:0]    rem_ff   [Q_W];
   logic [D_W-1:0]    div_ff   [Q_W];
   logic [Q_W-1:0]    quo_ff   [Q_W];
   logic [SIDE_W-1:0] side_ff  [Q_W];

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int SH = Q_W - 1 - s;
      logic              valid_prev;
      logic [N_W-1:0]    rem_prev, rem_in;
      logic [D_W-1:0]    div_prev;
      logic [Q_W-1:0]    quo_prev, quo_in;
      logic [SIDE_W-1:0] side_prev;
      logic [CW-1:0]     trial;
      logic              take;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = dividend;
         assign div_prev   = divisor;
         assign quo_prev   = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign div_prev   = div_ff[s-1];
         assign quo_prev   = quo_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      // compare and subtract the shifted divisor
      assign trial  = CW'(div_prev) << SH;
      assign take   = CW'(rem_prev) >= trial;
      assign rem_in = take ? N_W'(CW'(rem_prev) - trial) : rem_prev;
      assign quo_in = take ? (quo_prev | (Q_W'(1) << SH)) : quo_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_prev;
         end
         if (enable) begin
            rem_ff[s]  <= rem_in;
            div_ff[s]  <= div_prev;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign quotient  = quo_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

@@ hdl/psd_isqrt.sv @@
module psd_isqrt #(
   parameter int IN_W   = psd_pkg::ROOT_IN_W,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     value,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int R_W = IN_W / 2;

   logic              valid_ff [R_W];
   logic [R_W+1:0]    rem_ff   [R_W];
   logic [R_W-1:0]    root_ff  [R_W];
   logic [IN_W-1:0]   val_ff   [R_W];
   logic [SIDE_W-1:0] side_ff  [R_W];

   // one root bit per stage from the top bit pair down
   for (genvar s = 0; s < R_W; s++) begin : g_stage
      localparam int PI = R_W - 1 - s;
      logic              valid_prev;
      logic [R_W+1:0]    rem_prev, rem_cat, trial, rem_in;
      logic [R_W-1:0]    root_prev, root_in;
      logic [IN_W-1:0]   val_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              take;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign val_prev   = value;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign val_prev   = val_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      // bring down the next bit pair and try root*4+1
      assign rem_cat = {rem_prev[R_W-1:0], val_prev[2*PI+1 -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign take    = rem_cat >= trial;
      assign rem_in  = take ? rem_cat - trial : rem_cat;
      assign root_in = {root_prev[R_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_prev;
         end
         if (enable) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            val_ff[s]  <= val_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[R_W-1];
   assign root      = root_ff[R_W-1];
   assign out_side  = side_ff[R_W-1];

endmodule
